/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the tokenizer.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

/* rtl/core/slt_pkg.sv */
// Types, codes and helper functions of the stack language tokenizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package slt_pkg;

  // Longest name that a label, reference or command word may have.
  localparam int unsigned NameMax = 8;
  localparam int unsigned NumKeywords = 21;

  // Character codes the scanner looks for.
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChAt    = 8'h40;

  localparam logic [23:0] LineMax = 24'hff_ffff;
  localparam logic [15:0] ColMax  = 16'hffff;

  typedef enum logic [2:0] {
    KindLabel   = 3'd0,
    KindRef     = 3'd1,
    KindPush    = 3'd2,
    KindCommand = 3'd3,
    KindError   = 3'd4
  } slt_kind_e;

  typedef enum logic [2:0] {
    ErrColon    = 3'd0,
    ErrCommand  = 3'd1,
    ErrChar     = 3'd2,
    ErrDigit    = 3'd3,
    ErrTooLong  = 3'd4
  } slt_err_e;

  // Scanner modes, one-hot.
  typedef enum logic [6:0] {
    ModeIdle    = 7'b000_0001,
    ModeComment = 7'b000_0010,
    ModeLabel   = 7'b000_0100,
    ModeRef     = 7'b000_1000,
    ModeMinus   = 7'b001_0000,
    ModeNumber  = 7'b010_0000,
    ModeWord    = 7'b100_0000
  } slt_mode_e;

  // One result word.
  typedef struct packed {
    slt_kind_e          kind;
    logic [4:0]         cmd;
    logic signed [31:0] value;
    logic [63:0]        name;
    logic [3:0]         len;
    slt_err_e           err;
    logic [23:0]        line;
    logic [15:0]        col;
  } slt_res_t;

  // Hand-off from the scanner to the output buffer.
  typedef struct packed {
    logic       load;
    logic [1:0] count;
  } slt_push_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } slt_kw_t;

  // Keywords packed with the first letter in the low byte.
  localparam logic [63:0] KwName [NumKeywords] = '{
    64'h646461, 64'h627573, 64'h6c756d, 64'h766964, 64'h706d6a,
    64'h71656a, 64'h716e6a, 64'h74676a, 64'h746c6a, 64'h746567,
    64'h746573, 64'h707564, 64'h706f70, 64'h736f7070, 64'h657a6973,
    64'h70617773, 64'h676264, 64'h746e697270, 64'h746e69727063,
    64'h64616572, 64'h6461657263
  };

  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4, 4'd5
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  // Parallel compare of the name buffer against all keywords.
  function automatic slt_kw_t kw_find(input logic [63:0] name, input logic [3:0] len);
    slt_kw_t r;
    r = '0;
    for (int k = 0; k < NumKeywords; k++) begin
      if (!r.hit && name == KwName[k] && len == KwLen[k]) begin
        r.hit  = 1'b1;
        r.code = 5'(k);
      end
    end
    return r;
  endfunction

  function automatic slt_res_t mk_err(input slt_err_e code, input logic [23:0] line,
                                      input logic [15:0] col);
    slt_res_t r;
    r      = '0;
    r.kind = KindError;
    r.err  = code;
    r.line = line;
    r.col  = col;
    return r;
  endfunction

  function automatic slt_res_t mk_name(input slt_kind_e kind, input logic [63:0] name,
                                       input logic [3:0] len);
    slt_res_t r;
    r      = '0;
    r.kind = kind;
    r.name = name;
    r.len  = len;
    return r;
  endfunction

  function automatic slt_res_t mk_num(input logic [31:0] acc, input logic neg);
    slt_res_t r;
    r       = '0;
    r.kind  = KindPush;
    r.value = neg ? -acc : acc;
    return r;
  endfunction

  function automatic slt_res_t mk_cmd(input logic [4:0] code);
    slt_res_t r;
    r      = '0;
    r.kind = KindCommand;
    r.cmd  = code;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/slt_scan.sv */
// Input register, scanner state and the single-pass character step.
// Depends on slt_pkg; feeds up to two result words to slt_outbuf.
`default_nettype none

module slt_scan #(
  parameter int unsigned NameMax = slt_pkg::NameMax
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              end_of_text_i,
  input  wire logic              space_i,
  output slt_pkg::slt_push_t     push_o,
  output slt_pkg::slt_res_t      res_o [2]
);
  import slt_pkg::*;

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       eot_q;
  logic       fire;

  slt_mode_e   mode_q, mode_d;
  logic [63:0] nbuf_q, nbuf_d;
  logic [3:0]  ncnt_q, ncnt_d;
  logic [31:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [23:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic        halt_q, halt_d;
  logic [1:0]  nres_d;
  slt_res_t    res_d [2];

  logic        rescan;
  logic        do_add;
  logic        do_adv;
  slt_kw_t     kw;
  logic [31:0] digit;

  // The step runs once the output buffer can take its words.
  assign fire       = in_valid_q && space_i;
  assign in_ready_o = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      eot_q  <= end_of_text_i;
    end
  end

  assign kw    = kw_find(nbuf_q, ncnt_q);
  assign digit = 32'(char_q - ChZero);

  // Next state and results of one word.
  always_comb begin
    mode_d  = mode_q;
    nbuf_d  = nbuf_q;
    ncnt_d  = ncnt_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    line_d  = line_q;
    col_d   = col_q;
    halt_d  = halt_q;
    nres_d  = 2'd0;
    res_d[0] = '0;
    res_d[1] = '0;
    rescan  = 1'b0;
    do_add  = 1'b0;
    do_adv  = 1'b0;

    if (halt_q) begin
      // Halted after an error: ignore everything.
    end else if (eot_q) begin
      // End of input flushes the pending token.
      unique case (mode_q)
        ModeLabel: begin
          res_d[0] = mk_err(ErrColon, line_q, col_q);
          nres_d   = 2'd1;
          halt_d   = 1'b1;
        end
        ModeRef: begin
          res_d[0] = mk_name(KindRef, nbuf_q, ncnt_q);
          nres_d   = 2'd1;
        end
        ModeMinus: begin
          res_d[0] = mk_err(ErrDigit, line_q, col_q);
          nres_d   = 2'd1;
          halt_d   = 1'b1;
        end
        ModeNumber: begin
          res_d[0] = mk_num(acc_q, neg_q);
          nres_d   = 2'd1;
        end
        ModeWord: begin
          res_d[0] = kw.hit ? mk_cmd(kw.code) : mk_err(ErrCommand, line_q, col_q);
          nres_d   = 2'd1;
          halt_d   = !kw.hit;
        end
        default: begin
        end
      endcase
      mode_d = ModeIdle;
    end else begin
      // Continue the pending token.
      unique case (mode_q)
        ModeComment: begin
          do_adv = 1'b1;
          if (char_q == ChLf) begin
            mode_d = ModeIdle;
          end
        end
        ModeLabel: begin
          if (is_letter(char_q)) begin
            do_add = 1'b1;
          end else if (char_q == ChColon) begin
            res_d[0] = mk_name(KindLabel, nbuf_q, ncnt_q);
            nres_d   = 2'd1;
            do_adv   = 1'b1;
            mode_d   = ModeIdle;
          end else begin
            res_d[0] = mk_err(ErrColon, line_q, col_q);
            nres_d   = 2'd1;
            halt_d   = 1'b1;
            mode_d   = ModeIdle;
          end
        end
        ModeRef: begin
          if (is_letter(char_q)) begin
            do_add = 1'b1;
          end else begin
            res_d[0] = mk_name(KindRef, nbuf_q, ncnt_q);
            nres_d   = 2'd1;
            mode_d   = ModeIdle;
            rescan   = 1'b1;
          end
        end
        ModeMinus: begin
          if (is_digit(char_q)) begin
            acc_d  = digit;
            mode_d = ModeNumber;
            do_adv = 1'b1;
          end else begin
            res_d[0] = mk_err(ErrDigit, line_q, col_q);
            nres_d   = 2'd1;
            halt_d   = 1'b1;
            mode_d   = ModeIdle;
          end
        end
        ModeNumber: begin
          if (is_digit(char_q)) begin
            // Times ten as two shifts, wrapping at 32 bits.
            acc_d  = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + digit;
            do_adv = 1'b1;
          end else begin
            res_d[0] = mk_num(acc_q, neg_q);
            nres_d   = 2'd1;
            mode_d   = ModeIdle;
            rescan   = 1'b1;
          end
        end
        ModeWord: begin
          if (is_letter(char_q)) begin
            do_add = 1'b1;
          end else begin
            res_d[0] = kw.hit ? mk_cmd(kw.code) : mk_err(ErrCommand, line_q, col_q);
            nres_d   = 2'd1;
            halt_d   = !kw.hit;
            mode_d   = ModeIdle;
            rescan   = kw.hit;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      // Scan the character between tokens.
      if (rescan) begin
        if (is_blank(char_q)) begin
          do_adv = 1'b1;
        end else begin
          nbuf_d = '0;
          ncnt_d = '0;
          acc_d  = '0;
          neg_d  = 1'b0;
          if (char_q == ChHash) begin
            mode_d = ModeComment;
            do_adv = 1'b1;
          end else if (char_q == ChColon) begin
            mode_d = ModeLabel;
            do_adv = 1'b1;
          end else if (char_q == ChAt) begin
            mode_d = ModeRef;
            do_adv = 1'b1;
          end else if (char_q == ChMinus) begin
            neg_d  = 1'b1;
            mode_d = ModeMinus;
            do_adv = 1'b1;
          end else if (is_digit(char_q)) begin
            acc_d  = digit;
            mode_d = ModeNumber;
            do_adv = 1'b1;
          end else if (is_letter(char_q)) begin
            mode_d = ModeWord;
            do_add = 1'b1;
          end else begin
            res_d[nres_d[0]] = mk_err(ErrChar, line_q, col_q);
            nres_d = nres_d + 2'd1;
            halt_d = 1'b1;
            mode_d = ModeIdle;
          end
        end
      end

      // Append a letter to the name, or flag an overlong name.
      if (do_add) begin
        if (ncnt_d >= 4'(NameMax)) begin
          res_d[nres_d[0]] = mk_err(ErrTooLong, line_q, col_q);
          nres_d = nres_d + 2'd1;
          halt_d = 1'b1;
          mode_d = ModeIdle;
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (ncnt_d == 4'(i)) begin
              nbuf_d[8*i +: 8] = char_q;
            end
          end
          ncnt_d = ncnt_d + 4'd1;
          do_adv = 1'b1;
        end
      end

      // Line and column bookkeeping, both saturating.
      if (do_adv) begin
        if (char_q == ChLf) begin
          if (line_q != LineMax) begin
            line_d = line_q + 24'd1;
          end
          col_d = 16'd1;
        end else if (col_q != ColMax) begin
          col_d = col_q + 16'd1;
        end
      end
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      nbuf_q <= '0;
      ncnt_q <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      line_q <= 24'd1;
      col_q  <= 16'd1;
      halt_q <= 1'b0;
    end else if (fire) begin
      mode_q <= mode_d;
      nbuf_q <= nbuf_d;
      ncnt_q <= ncnt_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      line_q <= line_d;
      col_q  <= col_d;
      halt_q <= halt_d;
    end
  end

  assign push_o.load  = fire;
  assign push_o.count = nres_d;
  assign res_o[0]     = res_d[0];
  assign res_o[1]     = res_d[1];

endmodule

`default_nettype wire

/* rtl/core/slt_outbuf.sv */
// Result register for up to two words of one input item, shown one per cycle while the receiver takes them.
// Depends on slt_pkg; loaded by slt_scan.
`default_nettype none

module slt_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire slt_pkg::slt_push_t push_i,
  input  wire slt_pkg::slt_res_t res_i [2],
  output logic                   space_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output slt_pkg::slt_res_t      res_o,
  output logic                   last_o
);
  import slt_pkg::*;

  logic [1:0] cnt_q;
  logic       sel_q;
  slt_res_t   res_q [2];

  assign out_valid_o = cnt_q != 2'd0;
  assign last_o      = sel_q || cnt_q == 2'd1;
  assign res_o       = res_q[sel_q];
  // Free for the next item once the final word leaves.
  assign space_o     = !out_valid_o || (out_ready_i && last_o);

  // Word count and select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      sel_q <= 1'b0;
    end else if (push_i.load) begin
      cnt_q <= push_i.count;
      sel_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      if (last_o) begin
        cnt_q <= 2'd0;
        sel_q <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (push_i.load) begin
      res_q[0] <= res_i[0];
      res_q[1] <= res_i[1];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stack_language_tokenizer_unit.sv */
// Top level of the stack language tokenizer.
// Depends on slt_pkg, slt_scan and slt_outbuf.
//
// Usage:
//   The input channel takes one word per character (char_code_i) or an end
//   marker (end_of_text_i). The output channel gives token words: labels,
//   references, integer pushes, commands and errors, one word per handshake.
//   One input word gives zero, one or two output words; last_of_run_o marks
//   the final output word caused by an input word.
//   A result word passes the input register and then the result register;
//   the scan step waits while the result register has no space for it.
//   One input word per cycle while each gives at most one result and the
//   receiver takes every word; a word that gives two results holds the
//   scan stage while the two-entry result register drains.
//   Reset clears the scanner to idle between tokens, line and column to one,
//   and empties both registers. After an error word the block ignores all
//   input until reset.
//   When the receiver stalls, the result register holds; the input register
//   takes a word only while it is empty, and then input ready drops.
`default_nettype none

module stack_language_tokenizer_unit #(
  parameter int unsigned NameMax = slt_pkg::NameMax
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [4:0]       command_code_o,
  output logic signed [31:0] int_value_o,
  output logic [63:0]      name_chars_o,
  output logic [3:0]       name_length_o,
  output logic [2:0]       error_code_o,
  output logic [23:0]      error_line_o,
  output logic [15:0]      error_column_o,
  output logic             last_of_run_o
);
  import slt_pkg::*;

  slt_push_t push;
  slt_res_t  step_res [2];
  slt_res_t  out_res;
  logic      space;

  slt_scan #(
    .NameMax (NameMax)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .space_i       (space),
    .push_o        (push),
    .res_o         (step_res)
  );

  slt_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (step_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res),
    .last_o      (last_of_run_o)
  );

  // Result fields onto the ports.
  assign token_kind_o   = out_res.kind;
  assign command_code_o = out_res.cmd;
  assign int_value_o    = out_res.value;
  assign name_chars_o   = out_res.name;
  assign name_length_o  = out_res.len;
  assign error_code_o   = out_res.err;
  assign error_line_o   = out_res.line;
  assign error_column_o = out_res.col;

endmodule

`default_nettype wire

/* rtl/core/slt_checker.sv */
// Port-level checks of the tokenizer, bound to the top level.
// Depends on slt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  char_code_i,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  token_kind_o,
  input wire logic [4:0]  command_code_o,
  input wire logic signed [31:0] int_value_o,
  input wire logic [63:0] name_chars_o,
  input wire logic [3:0]  name_length_o,
  input wire logic [2:0]  error_code_o,
  input wire logic [23:0] error_line_o,
  input wire logic [15:0] error_column_o,
  input wire logic        last_of_run_o
);
  import slt_pkg::*;

  logic [8:0]   in_word;
  logic [151:0] out_word;

  // Whole payloads of both channels, for the hold checks.
  assign in_word  = {char_code_i, end_of_text_i};
  assign out_word = {token_kind_o, command_code_o, int_value_o, name_chars_o, name_length_o,
                     error_code_o, error_line_o, error_column_o, last_of_run_o};

  // A waiting input word holds.
  `SLT_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_word))

  // A stalled result word holds.
  `SLT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word))

  // An error always ends the run of its input word.
  `SLT_ASSERT_IMP(a_err_last, clk_i, rst_ni, out_valid_o && token_kind_o == KindError, last_of_run_o)

  // Once an error word is taken, nothing follows.
  `SLT_ASSERT_NXT(a_err_halt, clk_i, rst_ni, out_valid_o && out_ready_i && token_kind_o == KindError, !out_valid_o)

  // Only error words carry a position.
  `SLT_ASSERT_IMP(a_pos_err, clk_i, rst_ni, out_valid_o && token_kind_o != KindError, error_line_o == 24'd0 && error_column_o == 16'd0)

endmodule

bind stack_language_tokenizer_unit slt_checker u_slt_chk (.*);

`default_nettype wire
